// ===== hdl/sscp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sscp_pkg;

    localparam int POS_W     = 32;
    localparam int PER_W     = 24;
    localparam int MINP_W    = 16;
    localparam int DUTY_W    = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = 5;
    localparam int PC_W      = 4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MIN_POSITION = 2'd0;
    localparam cfg_idx_t REG_MAX_POSITION = 2'd1;
    localparam cfg_idx_t REG_MIN_PULSE_US = 2'd2;
    localparam cfg_idx_t REG_DUTY_Q8      = 2'd3;

    typedef logic [PC_W-1:0] upc_t;

    localparam upc_t ADDR_WAIT  = 4'd0;
    localparam upc_t ADDR_DIFF  = 4'd1;
    localparam upc_t ADDR_MAG   = 4'd2;
    localparam upc_t ADDR_ROUND = 4'd3;
    localparam upc_t ADDR_DIV1  = 4'd4;
    localparam upc_t ADDR_CAP   = 4'd5;
    localparam upc_t ADDR_DIV2  = 4'd6;
    localparam upc_t ADDR_MUL   = 4'd7;
    localparam upc_t ADDR_WIDTH = 4'd8;
    localparam upc_t ADDR_EMIT  = 4'd9;
    localparam upc_t ADDR_LAST  = ADDR_EMIT;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_DIFF,
        OP_MAG,
        OP_ROUND,
        OP_DIV,
        OP_CAP,
        OP_MUL,
        OP_WIDTH,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SKIP_BAD,
        COND_SKIP_SMALL,
        COND_DIV_BUSY,
        COND_NO_PULSES,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    typedef struct packed {
        logic no_input;
        logic bad;
        logic small_move;
        logic div_busy;
        logic no_pulses;
        logic out_busy;
    } flags_t;

endpackage

`default_nettype wire

// ===== hdl/sscp_ucode_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sscp_ucode_rom
    import sscp_pkg::*;
(
    input  wire upc_t pc,
    output uword_t    word
);

    always_comb
    begin
        case (pc)
            ADDR_WAIT:  word = '{op: OP_WAIT,  cond: COND_NO_INPUT,   target: ADDR_WAIT};
            ADDR_DIFF:  word = '{op: OP_DIFF,  cond: COND_NEVER,      target: ADDR_WAIT};
            ADDR_MAG:   word = '{op: OP_MAG,   cond: COND_SKIP_BAD,   target: ADDR_EMIT};
            ADDR_ROUND: word = '{op: OP_ROUND, cond: COND_SKIP_SMALL, target: ADDR_EMIT};
            ADDR_DIV1:  word = '{op: OP_DIV,   cond: COND_DIV_BUSY,   target: ADDR_DIV1};
            ADDR_CAP:   word = '{op: OP_CAP,   cond: COND_NO_PULSES,  target: ADDR_EMIT};
            ADDR_DIV2:  word = '{op: OP_DIV,   cond: COND_DIV_BUSY,   target: ADDR_DIV2};
            ADDR_MUL:   word = '{op: OP_MUL,   cond: COND_NEVER,      target: ADDR_WAIT};
            ADDR_WIDTH: word = '{op: OP_WIDTH, cond: COND_NEVER,      target: ADDR_WAIT};
            ADDR_EMIT:  word = '{op: OP_EMIT,  cond: COND_OUT_BUSY,   target: ADDR_EMIT};
            default:    word = '{op: OP_NOP,   cond: COND_ALWAYS,     target: ADDR_WAIT};
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/sscp_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sscp_divider
    import sscp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic             step,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic      [DIV_W-1:0] quotient,
    output logic                  busy
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_W-1:0]     dsr_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 ge;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign quotient = quo_reg;
    assign busy     = cnt_reg != '0;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        if (load)
        begin
            cnt_next = DIV_CNT_W'(DIV_W - 1);
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (step)
        begin
            if (busy)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

`default_nettype wire

// ===== hdl/sscp_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sscp_sequencer
    import sscp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire uword_t word,
    input  wire flags_t flags,
    output upc_t        pc
);

    upc_t pc_reg;
    upc_t pc_next;
    logic taken;

    assign pc = pc_reg;

    always_comb
    begin
        case (word.cond)
            COND_NEVER:      taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_NO_INPUT:   taken = flags.no_input;
            COND_SKIP_BAD:   taken = flags.bad;
            COND_SKIP_SMALL: taken = flags.small_move;
            COND_DIV_BUSY:   taken = flags.div_busy;
            COND_NO_PULSES:  taken = flags.no_pulses;
            COND_OUT_BUSY:   taken = flags.out_busy;
            default:         taken = 1'b1;
        endcase
    end

    always_comb
    begin
        priority if (taken)
        begin
            pc_next = word.target;
        end
        else if (pc_reg == ADDR_LAST)
        begin
            pc_next = ADDR_WAIT;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ADDR_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/stepper_step_command_planner.sv =====
// Step command planner: one command per control period.
// Input channel (in_valid/in_ready): goal_position, period_us. The block
// takes one item at a time; in_ready is high only while it waits for work.
// Output channel (out_valid/out_ready): status, pulse_count, direction,
// direction_changed, limited, step_cycle_us, high_time_us, position.
// Configuration: cfg_write with cfg_index 0..3 writes min_position,
// max_position, min_pulse_us, duty_q8 from cfg_data, no wait, no read-back.
// Steps: a full plan runs from acceptance to out_valid through difference,
// magnitude, rounding, 24-step cap division, cap, 24-step period division,
// multiply, width and output load; a refused target goes from magnitude
// straight to output load, as does a move under one pulse after rounding
// and zero pulses after the cap. Both divisions pass through the shared
// one-bit-per-cycle divider; a new item is taken only back in the wait step.
// A finished result sits in the output register; if the receiver stalls,
// the next item is still computed and waits in the output step until the
// register frees. Reset clears the tracked position and direction and loads
// the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module stepper_step_command_planner
    import sscp_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [POS_W-1:0] goal_position,
    input  wire logic [PER_W-1:0]        period_us,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         status,
    output logic [PER_W-1:0]             pulse_count,
    output logic                         direction,
    output logic                         direction_changed,
    output logic                         limited,
    output logic [PER_W-1:0]             step_cycle_us,
    output logic [PER_W-1:0]             high_time_us,
    output logic signed [POS_W-1:0]      position
);

    localparam logic [POS_W:0] ONE  = (POS_W + 1)'(1) << FRAC_BITS;
    localparam logic [POS_W:0] HALF = ONE >> 1;

    upc_t   pc;
    uword_t word;
    flags_t flags;

    logic signed [POS_W-1:0] min_pos_reg, min_pos_next;
    logic signed [POS_W-1:0] max_pos_reg, max_pos_next;
    logic [MINP_W-1:0]       min_pulse_reg, min_pulse_next;
    logic [DUTY_W-1:0]       duty_reg, duty_next;
    logic [POS_W-1:0]        tracked_reg, tracked_next;
    logic                    dir_reg, dir_next;
    logic                    out_valid_reg, out_valid_next;

    logic [POS_W-1:0]        desired_reg, desired_next;
    logic [PER_W-1:0]        period_reg, period_next;
    logic [POS_W:0]          diff_reg, diff_next;
    logic                    bad_reg, bad_next;
    logic                    near_reg, near_next;
    logic [POS_W-1:0]        mag_reg, mag_next;
    logic [POS_W:0]          count_reg, count_next;
    logic                    stat_w_reg, stat_w_next;
    logic                    chg_w_reg, chg_w_next;
    logic                    lim_w_reg, lim_w_next;
    logic [PER_W-1:0]        cyc_w_reg, cyc_w_next;
    logic [PER_W-1:0]        wid_w_reg, wid_w_next;
    logic [PER_W+DUTY_W-1:0] prod_reg, prod_next;

    logic                    o_stat_reg, o_stat_next;
    logic [PER_W-1:0]        o_cnt_reg, o_cnt_next;
    logic                    o_dir_reg, o_dir_next;
    logic                    o_chg_reg, o_chg_next;
    logic                    o_lim_reg, o_lim_next;
    logic [PER_W-1:0]        o_cyc_reg, o_cyc_next;
    logic [PER_W-1:0]        o_wid_reg, o_wid_next;
    logic [POS_W-1:0]        o_pos_reg, o_pos_next;

    logic signed [POS_W:0]   des_x, trk_x, min_x, max_x, half_x;
    logic [POS_W:0]          mag_full;
    logic [POS_W:0]          mag_ext;
    logic [POS_W:0]          rounded;
    logic [PER_W-1:0]        minp;
    logic [DIV_W-1:0]        quotient;
    logic                    div_busy;
    logic                    div_load;
    logic [DIV_W-1:0]        div_divisor;
    logic                    over;
    logic [PER_W-1:0]        cap_count;
    logic [POS_W-1:0]        move;
    logic [PER_W-1:0]        raw_width;
    logic                    out_free;
    logic                    small_move;
    logic                    new_dir;

    sscp_ucode_rom u_rom (
        .pc   (pc),
        .word (word)
    );

    sscp_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .word  (word),
        .flags (flags),
        .pc    (pc)
    );

    sscp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .step     (word.op == OP_DIV),
        .dividend (period_reg),
        .divisor  (div_divisor),
        .quotient (quotient),
        .busy     (div_busy)
    );

    assign in_ready   = word.op == OP_WAIT;
    assign out_free   = !out_valid_reg || out_ready;
    assign minp       = (min_pulse_reg == '0) ? PER_W'(1) : PER_W'(min_pulse_reg);

    assign des_x      = $signed({desired_reg[POS_W-1], desired_reg});
    assign trk_x      = $signed({tracked_reg[POS_W-1], tracked_reg});
    assign min_x      = $signed({min_pos_reg[POS_W-1], min_pos_reg});
    assign max_x      = $signed({max_pos_reg[POS_W-1], max_pos_reg});
    assign half_x     = $signed(HALF);

    assign mag_full   = diff_reg[POS_W] ? (~diff_reg + 1'b1) : diff_reg;
    assign mag_ext    = {1'b0, mag_reg};
    assign small_move = mag_ext < ONE;
    assign new_dir    = diff_reg[POS_W];
    assign rounded    = near_reg ? (mag_ext >> FRAC_BITS) : ((mag_ext + HALF) >> FRAC_BITS);

    assign over        = count_reg > (POS_W + 1)'(quotient);
    assign cap_count   = over ? quotient : count_reg[PER_W-1:0];
    assign div_load    = (word.op == OP_ROUND) || (word.op == OP_CAP);
    assign div_divisor = (word.op == OP_CAP) ? cap_count : minp;

    assign move       = count_reg[POS_W-1:0] << FRAC_BITS;
    assign raw_width  = prod_reg[PER_W+DUTY_W-1:DUTY_W];

    assign flags.no_input   = !in_valid;
    assign flags.bad        = bad_reg;
    assign flags.small_move = small_move;
    assign flags.div_busy   = div_busy;
    assign flags.no_pulses  = cap_count == '0;
    assign flags.out_busy   = !out_free;

    always_comb
    begin
        min_pos_next   = min_pos_reg;
        max_pos_next   = max_pos_reg;
        min_pulse_next = min_pulse_reg;
        duty_next      = duty_reg;
        tracked_next   = tracked_reg;
        dir_next       = dir_reg;
        out_valid_next = out_valid_reg;

        desired_next = desired_reg;
        period_next  = period_reg;
        diff_next    = diff_reg;
        bad_next     = bad_reg;
        near_next    = near_reg;
        mag_next     = mag_reg;
        count_next   = count_reg;
        stat_w_next  = stat_w_reg;
        chg_w_next   = chg_w_reg;
        lim_w_next   = lim_w_reg;
        cyc_w_next   = cyc_w_reg;
        wid_w_next   = wid_w_reg;
        prod_next    = prod_reg;

        o_stat_next = o_stat_reg;
        o_cnt_next  = o_cnt_reg;
        o_dir_next  = o_dir_reg;
        o_chg_next  = o_chg_reg;
        o_lim_next  = o_lim_reg;
        o_cyc_next  = o_cyc_reg;
        o_wid_next  = o_wid_reg;
        o_pos_next  = o_pos_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_POSITION: min_pos_next   = $signed(cfg_data);
                REG_MAX_POSITION: max_pos_next   = $signed(cfg_data);
                REG_MIN_PULSE_US: min_pulse_next = cfg_data[MINP_W-1:0];
                REG_DUTY_Q8:      duty_next      = cfg_data[DUTY_W-1:0];
                default:          duty_next      = duty_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (word.op)
            OP_WAIT:
            begin
                if (in_valid)
                begin
                    desired_next = goal_position;
                    period_next  = period_us;
                    count_next   = '0;
                    stat_w_next  = 1'b0;
                    chg_w_next   = 1'b0;
                    lim_w_next   = 1'b0;
                    cyc_w_next   = '0;
                    wid_w_next   = '0;
                end
            end
            OP_DIFF:
            begin
                diff_next = des_x - trk_x;
                bad_next  = (des_x < min_x) || (des_x > max_x);
                near_next = (des_x >= max_x - half_x) || (des_x <= min_x + half_x);
            end
            OP_MAG:
            begin
                mag_next    = mag_full[POS_W-1:0];
                stat_w_next = bad_reg;
            end
            OP_ROUND:
            begin
                if (!small_move)
                begin
                    dir_next   = new_dir;
                    chg_w_next = new_dir != dir_reg;
                    count_next = rounded;
                end
            end
            OP_CAP:
            begin
                count_next = (POS_W + 1)'(cap_count);
                lim_w_next = over;
            end
            OP_MUL:
            begin
                cyc_w_next = quotient;
                prod_next  = quotient * duty_reg;
            end
            OP_WIDTH:
            begin
                wid_w_next   = (raw_width < minp) ? minp : raw_width;
                tracked_next = dir_reg ? (tracked_reg - move) : (tracked_reg + move);
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_stat_next    = stat_w_reg;
                    o_cnt_next     = count_reg[PER_W-1:0];
                    o_dir_next     = dir_reg;
                    o_chg_next     = chg_w_reg;
                    o_lim_next     = lim_w_reg;
                    o_cyc_next     = cyc_w_reg;
                    o_wid_next     = wid_w_reg;
                    o_pos_next     = tracked_reg;
                end
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pos_reg   <= {1'b1, {(POS_W-1){1'b0}}};
            max_pos_reg   <= {1'b0, {(POS_W-1){1'b1}}};
            min_pulse_reg <= MINP_W'(5);
            duty_reg      <= DUTY_W'(128);
            tracked_reg   <= '0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_pos_reg   <= min_pos_next;
            max_pos_reg   <= max_pos_next;
            min_pulse_reg <= min_pulse_next;
            duty_reg      <= duty_next;
            tracked_reg   <= tracked_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desired_reg <= desired_next;
        period_reg  <= period_next;
        diff_reg    <= diff_next;
        bad_reg     <= bad_next;
        near_reg    <= near_next;
        mag_reg     <= mag_next;
        count_reg   <= count_next;
        stat_w_reg  <= stat_w_next;
        chg_w_reg   <= chg_w_next;
        lim_w_reg   <= lim_w_next;
        cyc_w_reg   <= cyc_w_next;
        wid_w_reg   <= wid_w_next;
        prod_reg    <= prod_next;
        o_stat_reg  <= o_stat_next;
        o_cnt_reg   <= o_cnt_next;
        o_dir_reg   <= o_dir_next;
        o_chg_reg   <= o_chg_next;
        o_lim_reg   <= o_lim_next;
        o_cyc_reg   <= o_cyc_next;
        o_wid_reg   <= o_wid_next;
        o_pos_reg   <= o_pos_next;
    end

    assign out_valid         = out_valid_reg;
    assign status            = o_stat_reg;
    assign pulse_count       = o_cnt_reg;
    assign direction         = o_dir_reg;
    assign direction_changed = o_chg_reg;
    assign limited           = o_lim_reg;
    assign step_cycle_us     = o_cyc_reg;
    assign high_time_us      = o_wid_reg;
    assign position          = $signed(o_pos_reg);

endmodule

`default_nettype wire

// ===== sim/step_plan_checker.sv =====
`timescale 1ns / 1ps

module step_plan_checker
    import sscp_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    input  wire logic                    in_ready,
    input  wire logic signed [POS_W-1:0] goal_position,
    input  wire logic [PER_W-1:0]        period_us,
    input  wire logic                    out_valid,
    input  wire logic                    out_ready,
    input  wire logic                    status,
    input  wire logic [PER_W-1:0]        pulse_count,
    input  wire logic                    direction,
    input  wire logic                    direction_changed,
    input  wire logic                    limited,
    input  wire logic [PER_W-1:0]        step_cycle_us,
    input  wire logic [PER_W-1:0]        high_time_us,
    input  wire logic signed [POS_W-1:0] position,
    output int                           fail_count,
    output int                           pending,
    output int                           n_plans,
    output int                           n_refused,
    output int                           n_capped,
    output int                           n_turns,
    output int                           n_still
);

    typedef struct {
        logic                    status;
        logic [PER_W-1:0]        pulse_count;
        logic                    direction;
        logic                    direction_changed;
        logic                    limited;
        logic [PER_W-1:0]        step_cycle_us;
        logic [PER_W-1:0]        high_time_us;
        logic signed [POS_W-1:0] position;
    } plan_t;

    plan_t                   planned_q[$];
    logic signed [POS_W-1:0] lo_limit;
    logic signed [POS_W-1:0] hi_limit;
    logic [MINP_W-1:0]       min_pulse;
    logic [DUTY_W-1:0]       duty;
    logic signed [POS_W-1:0] track_pos;
    logic                    cur_dir;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        n_plans    = 0;
        n_refused  = 0;
        n_capped   = 0;
        n_turns    = 0;
        n_still    = 0;
    end

    function automatic plan_t plan_period(input logic signed [POS_W-1:0] target,
                                          input logic [PER_W-1:0] per);
        plan_t  p;
        longint tgt;
        longint perl;
        longint diff;
        longint mag;
        longint one;
        longint half;
        longint minp;
        longint cnt;
        longint cyc;
        longint wid;
        longint mv;
        one  = longint'(1) << FRAC_BITS;
        half = one >> 1;
        tgt  = target;
        perl = per;
        minp = (min_pulse == '0) ? 1 : min_pulse;
        cnt  = 0;
        cyc  = 0;
        wid  = 0;
        p.status            = 1'b0;
        p.direction_changed = 1'b0;
        p.limited           = 1'b0;
        if (tgt < longint'(lo_limit) || tgt > longint'(hi_limit))
        begin
            p.status = 1'b1;
        end
        else
        begin
            diff = tgt - longint'(track_pos);
            mag  = (diff < 0) ? -diff : diff;
            if (mag >= one)
            begin
                if ((diff < 0) != cur_dir)
                begin
                    p.direction_changed = 1'b1;
                    cur_dir             = (diff < 0);
                end
                if (tgt >= longint'(hi_limit) - half || tgt <= longint'(lo_limit) + half)
                    cnt = mag >> FRAC_BITS;
                else
                    cnt = (mag + half) >> FRAC_BITS;
                if (cnt * minp > perl)
                begin
                    cnt       = perl / minp;
                    p.limited = 1'b1;
                end
                if (cnt != 0)
                begin
                    cyc = perl / cnt;
                    wid = (cyc * longint'(duty)) >> 8;
                    if (wid < minp)
                        wid = minp;
                    mv        = cnt * one;
                    track_pos = POS_W'(cur_dir ? longint'(track_pos) - mv
                                               : longint'(track_pos) + mv);
                end
            end
        end
        p.pulse_count   = PER_W'(cnt);
        p.step_cycle_us = PER_W'(cyc);
        p.high_time_us  = PER_W'(wid);
        p.direction     = cur_dir;
        p.position      = track_pos;
        return p;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        plan_t want;
        if (!rst_n)
        begin
            lo_limit  = 32'sh80000000;
            hi_limit  = 32'sh7FFFFFFF;
            min_pulse = 16'd5;
            duty      = 8'd128;
            track_pos = '0;
            cur_dir   = 1'b0;
            planned_q.delete();
            pending   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MIN_POSITION: lo_limit  = cfg_data;
                    REG_MAX_POSITION: hi_limit  = cfg_data;
                    REG_MIN_PULSE_US: min_pulse = cfg_data[MINP_W-1:0];
                    REG_DUTY_Q8:      duty      = cfg_data[DUTY_W-1:0];
                    default:          ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (planned_q.size() == 0)
                begin
                    $error("result item with no plan waiting");
                    fail_count++;
                end
                else
                begin
                    want = planned_q.pop_front();
                    check_field("status", want.status, status);
                    check_field("pulse_count", want.pulse_count, pulse_count);
                    check_field("direction", want.direction, direction);
                    check_field("direction_changed", want.direction_changed,
                                direction_changed);
                    check_field("limited", want.limited, limited);
                    check_field("step_cycle_us", want.step_cycle_us, step_cycle_us);
                    check_field("high_time_us", want.high_time_us, high_time_us);
                    check_field("position", want.position, position);
                    n_plans++;
                    if (want.status)
                        n_refused++;
                    if (want.limited)
                        n_capped++;
                    if (want.direction_changed)
                        n_turns++;
                    if (!want.status && want.pulse_count == '0)
                        n_still++;
                end
            end
            if (in_valid && in_ready)
                planned_q.insert(planned_q.size(), plan_period(goal_position, period_us));
            pending = planned_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import sscp_pkg::*;

    localparam int FRAC        = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 125;

    logic                    clk              = 1'b0;
    logic                    rst_n            = 1'b0;
    logic                    cfg_write        = 1'b0;
    cfg_idx_t                cfg_index        = REG_MIN_POSITION;
    logic [CFG_W-1:0]        cfg_data         = '0;
    logic                    in_valid         = 1'b0;
    logic                    in_ready;
    logic signed [POS_W-1:0] goal_position    = '0;
    logic [PER_W-1:0]        period_us        = 24'd1;
    logic                    out_valid;
    logic                    out_ready        = 1'b0;
    logic                    status;
    logic [PER_W-1:0]        pulse_count;
    logic                    direction;
    logic                    direction_changed;
    logic                    limited;
    logic [PER_W-1:0]        step_cycle_us;
    logic [PER_W-1:0]        high_time_us;
    logic signed [POS_W-1:0] position;

    int     fail_count;
    int     pending;
    int     n_plans;
    int     n_refused;
    int     n_capped;
    int     n_turns;
    int     n_still;
    int     cycle_count = 0;
    int     max_gap     = 11;
    int     hold_cycles = 0;
    longint cur_lo      = -64'sd2147483648;
    longint cur_hi      = 64'sd2147483647;
    longint last_target = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stepper_step_command_planner #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .goal_position    (goal_position),
        .period_us        (period_us),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .pulse_count      (pulse_count),
        .direction        (direction),
        .direction_changed(direction_changed),
        .limited          (limited),
        .step_cycle_us    (step_cycle_us),
        .high_time_us     (high_time_us),
        .position         (position)
    );

    step_plan_checker #(
        .FRAC_BITS(FRAC)
    ) i_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .goal_position    (goal_position),
        .period_us        (period_us),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .pulse_count      (pulse_count),
        .direction        (direction),
        .direction_changed(direction_changed),
        .limited          (limited),
        .step_cycle_us    (step_cycle_us),
        .high_time_us     (high_time_us),
        .position         (position),
        .fail_count       (fail_count),
        .pending          (pending),
        .n_plans          (n_plans),
        .n_refused        (n_refused),
        .n_capped         (n_capped),
        .n_turns          (n_turns),
        .n_still          (n_still)
    );

    task automatic send(input logic signed [POS_W-1:0] pos, input logic [PER_W-1:0] per);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        goal_position = pos;
        period_us     = per;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_config(input longint lo, input longint hi, input int minp,
                              input int dut);
        drain();
        write_reg(REG_MIN_POSITION, CFG_W'(lo));
        write_reg(REG_MAX_POSITION, CFG_W'(hi));
        write_reg(REG_MIN_PULSE_US, CFG_W'(minp));
        write_reg(REG_DUTY_Q8, CFG_W'(dut));
        cur_lo = lo;
        cur_hi = hi;
    endtask

    function automatic logic signed [POS_W-1:0] pick_target();
        longint v;
        longint step;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            step = longint'($urandom_range(0, 5000)) * 256 + longint'($urandom_range(0, 255));
            v    = $urandom_range(0, 1) ? last_target + step : last_target - step;
        end
        else if (r < 70)
            v = last_target - 255 + longint'($urandom_range(0, 510));
        else if (r < 80)
            v = $urandom_range(0, 1) ? cur_lo + longint'($urandom_range(0, 300))
                                     : cur_hi - longint'($urandom_range(0, 300));
        else if (r < 90)
            v = $urandom_range(0, 1) ? cur_lo - 1 - longint'($urandom_range(0, 100000))
                                     : cur_hi + 1 + longint'($urandom_range(0, 100000));
        else
            v = $signed($urandom);
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        return POS_W'(v);
    endfunction

    function automatic logic [PER_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return PER_W'($urandom_range(1, 200000));
        else if (r < 85)
            return PER_W'($urandom_range(1, 64));
        else
            return PER_W'($urandom_range(1, 24'hFFFFFF));
    endfunction

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int stall;
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, max_gap);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic signed [POS_W-1:0] tgt;
        longint                  a;
        longint                  b;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(32'sd0, 24'd1000);
        send(32'sd255, 24'd1000);
        send(-32'sd255, 24'd1000);
        send(32'sd2688, 24'd1000);
        send(32'sd3711, 24'd1);
        send(-32'sd25600, 24'hFFFFFF);
        send(32'sh7FFFFFFF, 24'hFFFFFF);
        send(32'sh80000000, 24'hFFFFFF);
        send(32'sh80000000, 24'hFFFFFF);

        set_config(-1000000, 1000000, 0, 1);
        send(32'sd1000001, 24'd5000);
        send(-32'sd1000001, 24'd5000);
        send(32'sh7FFFFFFF, 24'd1);
        send(32'sd999872, 24'd100000);
        send(32'sd1000000, 24'd100000);
        send(-32'sd999872, 24'd100000);
        send(-32'sd999871, 24'd100000);
        send(32'sd3000, 24'd7);

        set_config(-64'sd2147483648, 64'sd2147483647, 65535, 255);
        send(32'sd0, 24'hFFFFFF);
        send(32'sd76800, 24'd131070);
        send(-32'sd1280, 24'hFFFFFF);
        send(32'sd512, 24'd65534);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_config(-64'sd2147483648, 64'sd2147483647, 5, 128);
                1: set_config(-longint'($urandom_range(0, 4000000)),
                              longint'($urandom_range(0, 4000000)),
                              $urandom_range(1, 50), $urandom_range(1, 255));
                2: set_config(-64'sd2147483648, 64'sd2147483647, 65535, 255);
                3: set_config(-64'sd2147483648, longint'($signed($urandom)), 0, 1);
                4:
                begin
                    a = $signed($urandom);
                    b = $signed($urandom);
                    if (a > b)
                        set_config(b, a, $urandom_range(1, 1000), $urandom_range(1, 255));
                    else
                        set_config(a, b, $urandom_range(1, 1000), $urandom_range(1, 255));
                end
                default: set_config(-200000, 200000, 1, 128);
            endcase
            last_target = (cur_lo + cur_hi) / 2;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                max_gap = (i >= 20 && i < 50) ? 0 : 11;
                if (ph == 1 && i == 60)
                    hold_cycles = 400;
                if (i == 100)
                    drain();
                tgt = pick_target();
                if (tgt >= cur_lo && tgt <= cur_hi)
                    last_target = tgt;
                send(tgt, pick_period());
            end
        end

        max_gap = 11;
        drain();
        repeat (64) @(negedge clk);
        $display("Planned %0d periods: directed edge cases, then six limit and timing setups.",
                 n_plans);
        $display("Refused %0d, capped %0d, turned %0d, idle with no pulses %0d.",
                 n_refused, n_capped, n_turns, n_still);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
